// File: rtl/core/gbsgs_pkg.sv
// Shared types and constants for the GF(2^n) baby-step giant-step log core.
// Holds the controller state and datapath command/status types.
// No dependencies.
`timescale 1ns / 1ps

package gbsgs_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR  = 4'd1;

  // Register reset values (x^8+x^6+x^5+x^4+1, generator x)
  localparam int POLY_RESET = 369;
  localparam int GEN_RESET  = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INV_MUL,
    ST_INV_SQR,
    ST_GNT_INIT,
    ST_GNT_MUL,
    ST_GNT_SQR,
    ST_BABY,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INV_START,
    OP_POW_MUL,
    OP_POW_SQR,
    OP_GNT_START,
    OP_BABY,
    OP_SCAN_START,
    OP_SCAN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   res_load;
    logic   res_found;
  } dp_cmd_t;

  typedef struct packed {
    logic target_zero;
    logic exp_last;
    logic baby_last;
    logic scan_hit;
    logic scan_miss;
  } dp_stat_t;

endpackage

// File: rtl/core/gbsgs_mul.sv
// Combinational GF(2^n) multiplier, shift-and-add with polynomial reduction.
// The top coefficient of the field polynomial is implied; red_i holds the rest.
// No dependencies.
`timescale 1ns / 1ps

module gbsgs_mul #(
  parameter int FIELD_BITS = 8
) (
  input  logic [FIELD_BITS-1:0] a_i,
  input  logic [FIELD_BITS-1:0] b_i,
  input  logic [FIELD_BITS-1:0] red_i,
  output logic [FIELD_BITS-1:0] p_o
);

  // One partial product per bit of b, a advanced by x each step
  always_comb begin
    logic [FIELD_BITS-1:0] a_v;
    logic [FIELD_BITS-1:0] acc;
    logic                  carry;
    a_v = a_i;
    acc = '0;
    for (int k = 0; k < FIELD_BITS; k++) begin
      if (b_i[k]) begin
        acc = acc ^ a_v;
      end
      carry = a_v[FIELD_BITS-1];
      a_v   = {a_v[FIELD_BITS-2:0], 1'b0};
      if (carry) begin
        a_v = a_v ^ red_i;
      end
    end
    p_o = acc;
  end

endmodule

// File: rtl/core/gbsgs_dp.sv
// Datapath: config registers, baby-step table memory, power unit and scan pipe.
// All products go through one shared gbsgs_mul instance.
// Depends on gbsgs_pkg and gbsgs_mul.
`timescale 1ns / 1ps

module gbsgs_dp #(
  parameter int FIELD_BITS = 8,
  parameter int BABY_STEPS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gbsgs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [FIELD_BITS-1:0]            cfg_data_i,
  input  logic [FIELD_BITS-1:0]            target_i,
  input  gbsgs_pkg::dp_cmd_t               cmd_i,
  output gbsgs_pkg::dp_stat_t              stat_o,
  output logic [FIELD_BITS-1:0]            log_value_o,
  output logic                             found_o
);

  import gbsgs_pkg::*;

  localparam int ORDER = (1 << FIELD_BITS) - 1;
  localparam int JW    = $clog2(BABY_STEPS);
  localparam int BW    = $clog2(BABY_STEPS + 1);
  localparam int EW    = (FIELD_BITS > BW) ? FIELD_BITS : BW;

  localparam logic [FIELD_BITS-1:0] X_LAST = FIELD_BITS'(ORDER - 1);
  localparam logic [JW-1:0]         J_LAST = JW'(BABY_STEPS - 1);

  // Configuration registers
  logic [FIELD_BITS-1:0] red_q, gen_q;

  // Working registers
  logic [FIELD_BITS-1:0] target_q, pw_q, base_q, acc_q, run_q, rd_q;
  logic [EW-1:0]         exp_q;
  logic [JW-1:0]         j_q;
  logic [FIELD_BITS-1:0] x_q, cmp_x_q;
  logic                  cmp_vld_q, cmp_last_q, iss_end_q;
  logic [FIELD_BITS-1:0] out_log_q;
  logic                  out_found_q;

  logic [FIELD_BITS-1:0] tbl_mem [BABY_STEPS];

  logic [FIELD_BITS-1:0] mul_a, mul_b, mul_p;
  logic                  hit, miss, advance, issue;

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q <= FIELD_BITS'(POLY_RESET);
      gen_q <= FIELD_BITS'(GEN_RESET);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_FIELD_POLY) begin
        red_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_GENERATOR) begin
        gen_q <= cfg_data_i;
      end
    end
  end

  // Shared multiplier operand select
  always_comb begin
    case (cmd_i.op)
      OP_POW_MUL: begin
        mul_a = acc_q;
        mul_b = base_q;
      end
      OP_POW_SQR: begin
        mul_a = base_q;
        mul_b = base_q;
      end
      OP_BABY: begin
        mul_a = pw_q;
        mul_b = gen_q;
      end
      default: begin
        mul_a = run_q;
        mul_b = acc_q;
      end
    endcase
  end

  gbsgs_mul #(
    .FIELD_BITS(FIELD_BITS)
  ) u_mul (
    .a_i  (mul_a),
    .b_i  (mul_b),
    .red_i(red_q),
    .p_o  (mul_p)
  );

  // Scan compare on the registered table word
  assign hit     = (cmd_i.op == OP_SCAN) && cmp_vld_q && (rd_q == run_q);
  assign miss    = (cmd_i.op == OP_SCAN) && cmp_vld_q && (rd_q != run_q) &&
                   (cmp_x_q == X_LAST);
  assign advance = (cmd_i.op == OP_SCAN) && !hit && !miss;
  assign issue   = advance && !iss_end_q;

  // Table memory: written during baby steps, read one word a cycle in the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_BABY) begin
      tbl_mem[j_q] <= pw_q;
    end
    if (issue) begin
      rd_q <= tbl_mem[j_q];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: target_q <= target_i;
      OP_INV_START: begin
        base_q <= gen_q;
        acc_q  <= FIELD_BITS'(1);
        exp_q  <= EW'(ORDER - 1);
        pw_q   <= FIELD_BITS'(1);
      end
      OP_GNT_START: begin
        base_q <= acc_q;
        acc_q  <= FIELD_BITS'(1);
        exp_q  <= EW'(BABY_STEPS);
      end
      OP_POW_MUL: begin
        if (exp_q[0]) begin
          acc_q <= mul_p;
        end
      end
      OP_POW_SQR: begin
        base_q <= mul_p;
        exp_q  <= exp_q >> 1;
      end
      OP_BABY: pw_q <= mul_p;
      OP_SCAN_START: run_q <= target_q;
      OP_SCAN: begin
        // next giant step once a row of the table is through
        if (cmp_vld_q && !hit && cmp_last_q) begin
          run_q <= mul_p;
        end
        if (advance) begin
          cmp_x_q    <= x_q;
          cmp_last_q <= (j_q == J_LAST);
        end
      end
      default: ;
    endcase
    if (cmd_i.res_load) begin
      out_found_q <= cmd_i.res_found;
      out_log_q   <= cmd_i.res_found ? cmp_x_q : '0;
    end
  end

  // Counters and scan pipe control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q       <= '0;
      x_q       <= '0;
      cmp_vld_q <= 1'b0;
      iss_end_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        OP_INV_START: j_q <= '0;
        OP_BABY:      j_q <= (j_q == J_LAST) ? '0 : j_q + 1'b1;
        OP_SCAN_START: begin
          j_q       <= '0;
          x_q       <= '0;
          cmp_vld_q <= 1'b0;
          iss_end_q <= 1'b0;
        end
        OP_SCAN: begin
          if (advance) begin
            cmp_vld_q <= !iss_end_q;
          end
          if (issue) begin
            j_q       <= (j_q == J_LAST) ? '0 : j_q + 1'b1;
            x_q       <= x_q + 1'b1;
            iss_end_q <= (x_q == X_LAST);
          end
        end
        default: ;
      endcase
    end
  end

  // Status to the controller
  always_comb begin
    stat_o.target_zero = (target_q == '0);
    stat_o.exp_last    = (exp_q[EW-1:1] == '0);
    stat_o.baby_last   = (j_q == J_LAST);
    stat_o.scan_hit    = hit;
    stat_o.scan_miss   = miss;
  end

  assign log_value_o = out_log_q;
  assign found_o     = out_found_q;

endmodule

// File: rtl/core/gbsgs_ctrl.sv
// Controller FSM: sequences power, baby-step, scan phases and the output word.
// Owns the output valid flag and the input ready.
// Depends on gbsgs_pkg.
`timescale 1ns / 1ps

module gbsgs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  gbsgs_pkg::dp_stat_t stat_i,
  output gbsgs_pkg::dp_cmd_t  cmd_o
);

  import gbsgs_pkg::*;

  state_e state_q, state_d;
  logic   found_q, found_d;
  logic   out_vld_q, out_vld_d;
  logic   out_free;

  assign out_free = !out_vld_q || m_tready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    found_d = found_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.target_zero) begin
          found_d = 1'b0;
          state_d = ST_FINISH;
        end else begin
          state_d = ST_INV_MUL;
        end
      end
      ST_INV_MUL: state_d = ST_INV_SQR;
      ST_INV_SQR: state_d = stat_i.exp_last ? ST_GNT_INIT : ST_INV_MUL;
      ST_GNT_INIT: state_d = ST_GNT_MUL;
      ST_GNT_MUL: state_d = ST_GNT_SQR;
      ST_GNT_SQR: state_d = stat_i.exp_last ? ST_BABY : ST_GNT_MUL;
      ST_BABY: begin
        if (stat_i.baby_last) begin
          state_d = ST_SCAN_INIT;
        end
      end
      ST_SCAN_INIT: state_d = ST_SCAN;
      ST_SCAN: begin
        if (stat_i.scan_hit) begin
          found_d = 1'b1;
          state_d = ST_FINISH;
        end else if (stat_i.scan_miss) begin
          found_d = 1'b0;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    s_tready_o      = 1'b0;
    cmd_o.op        = OP_NONE;
    cmd_o.res_load  = 1'b0;
    cmd_o.res_found = found_q;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.op   = s_tvalid_i ? OP_LOAD : OP_NONE;
      end
      ST_CHECK:     cmd_o.op = OP_INV_START;
      ST_INV_MUL:   cmd_o.op = OP_POW_MUL;
      ST_INV_SQR:   cmd_o.op = OP_POW_SQR;
      ST_GNT_INIT:  cmd_o.op = OP_GNT_START;
      ST_GNT_MUL:   cmd_o.op = OP_POW_MUL;
      ST_GNT_SQR:   cmd_o.op = OP_POW_SQR;
      ST_BABY:      cmd_o.op = OP_BABY;
      ST_SCAN_INIT: cmd_o.op = OP_SCAN_START;
      ST_SCAN:      cmd_o.op = OP_SCAN;
      ST_FINISH:    cmd_o.res_load = out_free;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  // Output word valid: set on load, cleared when taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.res_load) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign m_tvalid_o = out_vld_q;

  // A result never overwrites a word the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!out_vld_q || m_tready_i))
    else $error("result loaded over a pending output word");

  // An accepted word starts the zero check next cycle
  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == ST_CHECK))
    else $error("accepted word did not enter the check state");

  // A table hit ends the scan with a found result pending
  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && stat_i.scan_hit) |=> (state_q == ST_FINISH && found_q))
    else $error("scan hit not reported as found");

endmodule

// File: rtl/core/gf2n_discrete_log_bsgs_core.sv
// Top level of the GF(2^n) baby-step giant-step discrete log core.
// Ties the controller to the datapath and packs the stream words.
// Depends on gbsgs_pkg, gbsgs_ctrl, gbsgs_dp and gbsgs_mul.
//
// Usage:
//   s_* channel takes one target element per word; m_* returns one word per
//   target with the logarithm in tdata and the found flag in tuser.
//   cfg_* writes the field polynomial (index 0) or the generator (index 1);
//   it is always ready and must only be used while the core is idle.
// Sequence (n = FIELD_BITS, B = BABY_STEPS):
//   a zero target goes from the check state straight to the result. Otherwise
//   the check, a multiply/square loop for generator^(2^n-2), a second loop for
//   the giant factor, B baby steps and a setup state precede the scan, which
//   reads one table word per cycle and ends on a hit or, on a miss, once the
//   exponent 2^n-2 has been compared. One item is in work at a time; the next
//   is accepted the cycle after the result loads, while that word may still
//   wait for tready.
// Reset: registers return to polynomial 0x171 and generator 2, no word
//   pending. A stalled receiver holds the output word; the core then parks
//   its next finished result until the output register frees.
`timescale 1ns / 1ps

module gf2n_discrete_log_bsgs_core #(
  parameter int FIELD_BITS = 8,
  parameter int BABY_STEPS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // target
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  input  logic [((FIELD_BITS+7)/8)*8-1:0] s_tdata_i,   // [n-1:0] target
  // result
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [((FIELD_BITS+7)/8)*8-1:0] m_tdata_o,   // [n-1:0] log_value
  output logic [0:0]                      m_tuser_o,   // [0] found
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gbsgs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FIELD_BITS:0]             cfg_data_i
);

  import gbsgs_pkg::*;

  localparam int TDW = ((FIELD_BITS + 7) / 8) * 8;

  dp_cmd_t               cmd;
  dp_stat_t              stat;
  logic [FIELD_BITS-1:0] log_value;
  logic                  found;

  assign cfg_ready_o = 1'b1;

  gbsgs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Bit n of the polynomial is implied, so only the low n bits go down
  gbsgs_dp #(
    .FIELD_BITS(FIELD_BITS),
    .BABY_STEPS(BABY_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i[FIELD_BITS-1:0]),
    .target_i   (s_tdata_i[FIELD_BITS-1:0]),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .log_value_o(log_value),
    .found_o    (found)
  );

  assign m_tdata_o = TDW'(log_value);
  assign m_tuser_o = found;

endmodule
